// ===== src/dqs_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Sizes, opcodes, status codes, ring arithmetic and the store port types
// shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package dqs_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int OP_W  = 3;
   localparam int ST_W  = 2;
   localparam int VAL_W = 32;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

   localparam logic [ST_W-1:0] STS_DONE  = 2'd0;
   localparam logic [ST_W-1:0] STS_FULL  = 2'd1;
   localparam logic [ST_W-1:0] STS_EMPTY = 2'd2;

   typedef struct packed {
      logic                    en;
      logic [IDX_W-1:0]        addr;
      logic signed [VAL_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } store_rd_type;

   // (base + offset) mod DEPTH, with offset at most DEPTH
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== src/dqs_if.sv =====
// ----------------------------------------------------------------------------
// Deque channels
// Valid/ready channels for the request item and the response item.
// ----------------------------------------------------------------------------
interface dqs_req_if
   import dqs_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         opcode;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface dqs_rsp_if
   import dqs_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [ST_W-1:0]  status;
   logic             found;
   logic [CNT_W-1:0] count;

   modport source (output valid, output status, output found, output count, input ready);
   modport sink   (input valid, input status, input found, input count, output ready);
endinterface

// ===== src/dqs_store.sv =====
// ----------------------------------------------------------------------------
// Deque ring store
// DEPTH words, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dqs_store
   import dqs_pkg::*;
(
   input  logic                    clock,
   input  store_wr_type            wr,
   input  store_rd_type            rd,
   output logic signed [VAL_W-1:0] rd_data
);

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/double_ended_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue with search
// Bounded deque of signed 32-bit words held in a ring store, with a key scan.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one item per operation: opcode and value. rsp_ch returns
//   exactly one item per request: status, found flag and the count held after
//   the operation. Both channels move an item when valid and ready are high.
//   Push, pop, clear and unused opcodes, and a search on an empty queue, have
//   the response registered at the edge that accepts the request. A search
//   on a non-empty queue reads each held word from the head onward, then
//   registers the response: the single read port of the ring store delivers
//   one word per cycle and each compare follows in the cycle after its read.
//   One request is in flight at a time; req_ch.ready is high while the block
//   is idle and the response register is empty or being drained in the same
//   cycle, so a stalled receiver holds the response and blocks new requests.
//   A synchronous reset empties the queue (count 0, head 0) and drops any
//   pending response; stored words are not cleared and are never read
//   before being written.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search
   import dqs_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   dqs_req_if.sink   req_ch,
   dqs_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [VAL_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic                    hit_ff, hit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]         rsp_status_ff, rsp_status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;

   store_wr_type            wr;
   store_rd_type            rd;
   logic signed [VAL_W-1:0] rd_data;
   logic                    accept;
   logic                    full;
   logic                    empty;
   logic                    last_read;

   dqs_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   assign req_ch.ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept        = req_ch.valid && req_ch.ready;
   assign full          = (count_ff == CNT_W'(DEPTH));
   assign empty         = (count_ff == '0);
   assign last_read     = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff;

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.found  = rsp_found_ff;
   assign rsp_ch.count  = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_vld_in    = 1'b0;
      hit_in        = hit_ff | (cmp_vld_ff && (rd_data == key_ff));
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      wr.en         = 1'b0;
      wr.addr       = head_ff;
      wr.data       = req_ch.value;
      rd.en         = 1'b0;
      rd.addr       = ring_add(head_ff, CNT_W'(rd_idx_ff));

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_DONE;
               rsp_found_in  = 1'b0;
               hit_in        = 1'b0;
               key_in        = req_ch.value;
               rd_idx_in     = '0;
               unique case (req_ch.opcode)
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        head_in  = ring_add(head_ff, CNT_W'(DEPTH - 1));
                        wr.en    = 1'b1;
                        wr.addr  = head_in;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        wr.en    = 1'b1;
                        wr.addr  = ring_add(head_ff, count_ff);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        head_in  = ring_add(head_ff, CNT_W'(1));
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_SEARCH: begin
                     if (!empty) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     head_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         ST_SCAN: begin
            rd.en      = 1'b1;
            cmp_vld_in = 1'b1;
            rd_idx_in  = rd_idx_ff + IDX_W'(1);
            if (last_read) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STS_DONE;
            rsp_found_in  = hit_in;
            rsp_count_in  = count_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
